// ===== design/bump_map_normal_perturb_assert.svh =====
// Assertion macros shared by the checker.
`ifndef BUMP_MAP_NORMAL_PERTURB_ASSERT_SVH
`define BUMP_MAP_NORMAL_PERTURB_ASSERT_SVH

// same-cycle implication
`define BMNP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bmnp same-cycle check failed");

// next-cycle implication
`define BMNP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bmnp next-cycle check failed");

`endif

// ===== design/bmnp_pkg.sv =====
`default_nettype none

package bmnp_pkg;

    localparam int N_W       = 16;
    localparam int UNIT_BITS = 15;
    localparam int RSH       = 2 * UNIT_BITS;
    localparam int K_W       = UNIT_BITS + 2;
    localparam int D_W       = 18;
    localparam int DEN_W     = 34;
    localparam int QUO_W     = RSH + 1;
    localparam int ROOT_BITS = UNIT_BITS + 1;
    localparam int SQ_W      = QUO_W + 2;
    localparam int P0_W      = 2 * K_W;
    localparam int Q_W       = N_W + K_W;
    localparam int MID_W     = Q_W + 1;
    localparam int T_W       = MID_W + K_W;

    localparam logic signed [N_W-1:0] OUT_MAX = 16'sh7fff;
    localparam logic signed [N_W-1:0] OUT_MIN = 16'sh8000;
    localparam logic signed [K_W-1:0] K_ONE   = K_W'(2 ** UNIT_BITS);

    typedef struct packed {
        logic                  bump;
        logic signed [N_W-1:0] nx;
        logic signed [N_W-1:0] ny;
        logic signed [N_W-1:0] nz;
    } pass_t;

    typedef struct packed {
        pass_t      pass;
        logic [2:0] neg;
        logic       degen;
        logic       tz_neg;
    } side_t;

    typedef struct packed {
        pass_t                 pass;
        logic signed [K_W-1:0] k0;
        logic signed [K_W-1:0] k1;
        logic signed [K_W-1:0] k2;
        logic signed [K_W-1:0] tx;
        logic signed [K_W-1:0] tz;
    } comb_in_t;

    typedef struct packed {
        logic signed [N_W-1:0] x;
        logic signed [N_W-1:0] y;
        logic signed [N_W-1:0] z;
        logic                  clip;
    } res_t;

endpackage

`default_nettype wire

// ===== design/bmnp_div.sv =====
`default_nettype none

module bmnp_div (
    input  logic                        clk,
    input  logic                        en,
    input  logic [bmnp_pkg::DEN_W-1:0]  num,
    input  logic [bmnp_pkg::DEN_W-1:0]  den,
    output logic [bmnp_pkg::QUO_W-1:0]  quo
);
    import bmnp_pkg::*;

    logic [DEN_W-1:0] rem_reg [QUO_W];
    logic [DEN_W-1:0] den_reg [QUO_W];
    logic [QUO_W-1:0] quo_reg [QUO_W];

    for (genvar s = 0; s < QUO_W; s++)
    begin : g_stage
        logic [DEN_W:0]   rem_in;
        logic [DEN_W-1:0] den_in;
        logic [QUO_W-1:0] quo_in;
        logic             ge;
        logic [DEN_W-1:0] rem_next;
        logic [QUO_W-1:0] quo_next;

        if (s == 0)
        begin : g_first
            assign rem_in = {1'b0, num};
            assign den_in = den;
            assign quo_in = '0;
        end
        else
        begin : g_rest
            assign rem_in = {rem_reg[s-1], 1'b0};
            assign den_in = den_reg[s-1];
            assign quo_in = quo_reg[s-1];
        end

        assign ge       = rem_in >= {1'b0, den_in};
        assign rem_next = ge ? DEN_W'(rem_in - {1'b0, den_in}) : rem_in[DEN_W-1:0];
        assign quo_next = {quo_in[QUO_W-2:0], ge};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s] <= rem_next;
                den_reg[s] <= den_in;
                quo_reg[s] <= quo_next;
            end
        end
    end

    assign quo = quo_reg[QUO_W-1];

endmodule

`default_nettype wire

// ===== design/bmnp_sqrt.sv =====
`default_nettype none

module bmnp_sqrt (
    input  logic                           clk,
    input  logic                           en,
    input  logic [bmnp_pkg::QUO_W-1:0]     val,
    output logic [bmnp_pkg::ROOT_BITS-1:0] root
);
    import bmnp_pkg::*;

    logic [SQ_W-1:0] v_reg [ROOT_BITS];
    logic [SQ_W-1:0] r_reg [ROOT_BITS];

    for (genvar s = 0; s < ROOT_BITS; s++)
    begin : g_stage
        localparam logic [SQ_W-1:0] BIT_C = SQ_W'(1) << (2 * (ROOT_BITS - 1 - s));
        logic [SQ_W-1:0] v_in;
        logic [SQ_W-1:0] r_in;
        logic [SQ_W-1:0] trial;
        logic            ge;
        logic [SQ_W-1:0] v_next;
        logic [SQ_W-1:0] r_next;

        if (s == 0)
        begin : g_first
            assign v_in = SQ_W'(val);
            assign r_in = '0;
        end
        else
        begin : g_rest
            assign v_in = v_reg[s-1];
            assign r_in = r_reg[s-1];
        end

        assign trial  = r_in + BIT_C;
        assign ge     = v_in >= trial;
        assign v_next = ge ? v_in - trial : v_in;
        assign r_next = ge ? (r_in >> 1) + BIT_C : r_in >> 1;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                v_reg[s] <= v_next;
                r_reg[s] <= r_next;
            end
        end
    end

    assign root = r_reg[ROOT_BITS-1][ROOT_BITS-1:0];

endmodule

`default_nettype wire

// ===== design/bmnp_delay.sv =====
`default_nettype none

module bmnp_delay #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic         in_valid,
    input  logic [W-1:0] in_data,
    output logic         out_valid,
    output logic [W-1:0] out_data
);

    logic [DEPTH-1:0] valid_reg;
    logic [W-1:0]     data_reg [DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[DEPTH-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg[0] <= in_data;
            for (int i = 1; i < DEPTH; i++)
            begin
                data_reg[i] <= data_reg[i-1];
            end
        end
    end

    assign out_valid = valid_reg[DEPTH-1];
    assign out_data  = data_reg[DEPTH-1];

endmodule

`default_nettype wire

// ===== design/bmnp_combine.sv =====
`default_nettype none

module bmnp_combine #(
    parameter int FRAC_BITS = 14
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  bmnp_pkg::comb_in_t in_data,
    output logic               out_valid,
    output bmnp_pkg::res_t     out_data
);
    import bmnp_pkg::*;

    localparam int SW   = FRAC_BITS + 50;
    localparam int RQ_W = SW - RSH + 1;
    localparam logic [SW-1:0] HALF = SW'(1) << (RSH - 1);

    function automatic logic signed [RQ_W-1:0] round_q(input logic signed [SW-1:0] s);
        logic [SW-1:0]     mag;
        logic [SW-1:0]     sum;
        logic [RQ_W-1:0]   q;
        mag = s[SW-1] ? $unsigned(-s) : $unsigned(s);
        sum = mag + HALF;
        q   = {1'b0, sum[SW-1:RSH]};
        return s[SW-1] ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic [N_W:0] sat_q(input logic signed [RQ_W-1:0] r);
        logic [N_W:0] res;
        if (r > RQ_W'(OUT_MAX))
        begin
            res = {1'b1, OUT_MAX};
        end
        else if (r < RQ_W'(OUT_MIN))
        begin
            res = {1'b1, OUT_MIN};
        end
        else
        begin
            res = {1'b0, r[N_W-1:0]};
        end
        return res;
    endfunction

    logic [4:0] valid_reg;

    pass_t                  pass1_reg, pass2_reg, pass3_reg, pass4_reg, pass5_reg;
    logic signed [K_W-1:0]  k1_1_reg, k1_2_reg;
    logic signed [P0_W-1:0] p0x1_reg, p0z1_reg, p0x2_reg, p0z2_reg, p0x3_reg, p0z3_reg;
    logic signed [Q_W-1:0]  by1_reg, bym1_reg, bz1_reg, bz2_reg, by2_reg;
    logic signed [Q_W-1:0]  qx1_reg, qy1_reg, qz1_reg, qx2_reg, qy2_reg, qz2_reg;
    logic signed [Q_W-1:0]  qx3_reg, qy3_reg, qz3_reg;
    logic signed [MID_W-1:0] bmid2_reg, nbym2_reg;
    logic signed [T_W-1:0]  tax3_reg, tay3_reg, taz3_reg;
    logic signed [SW-1:0]   sx4_reg, sy4_reg, sz4_reg;
    logic signed [RQ_W-1:0] rx5_reg, ry5_reg, rz5_reg;

    logic [N_W:0] satx, saty, satz;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pass1_reg <= in_data.pass;
            k1_1_reg  <= in_data.k1;
            p0x1_reg  <= P0_W'(in_data.k0) * P0_W'(in_data.tx);
            p0z1_reg  <= P0_W'(in_data.k0) * P0_W'(in_data.tz);
            by1_reg   <= Q_W'(in_data.pass.ny) * Q_W'(in_data.tz);
            bym1_reg  <= Q_W'(in_data.pass.ny) * Q_W'(in_data.tx);
            bz1_reg   <= Q_W'(in_data.pass.nz) * Q_W'(in_data.tx);
            bz2_reg   <= Q_W'(in_data.pass.nx) * Q_W'(in_data.tz);
            qx1_reg   <= Q_W'(in_data.k2) * Q_W'(in_data.pass.nx);
            qy1_reg   <= Q_W'(in_data.k2) * Q_W'(in_data.pass.ny);
            qz1_reg   <= Q_W'(in_data.k2) * Q_W'(in_data.pass.nz);

            pass2_reg <= pass1_reg;
            k1_2_reg  <= k1_1_reg;
            p0x2_reg  <= p0x1_reg;
            p0z2_reg  <= p0z1_reg;
            by2_reg   <= by1_reg;
            bmid2_reg <= MID_W'(bz1_reg) - MID_W'(bz2_reg);
            nbym2_reg <= -MID_W'(bym1_reg);
            qx2_reg   <= qx1_reg;
            qy2_reg   <= qy1_reg;
            qz2_reg   <= qz1_reg;

            pass3_reg <= pass2_reg;
            p0x3_reg  <= p0x2_reg;
            p0z3_reg  <= p0z2_reg;
            tax3_reg  <= T_W'(k1_2_reg) * T_W'(by2_reg);
            tay3_reg  <= T_W'(k1_2_reg) * T_W'(bmid2_reg);
            taz3_reg  <= T_W'(k1_2_reg) * T_W'(nbym2_reg);
            qx3_reg   <= qx2_reg;
            qy3_reg   <= qy2_reg;
            qz3_reg   <= qz2_reg;

            pass4_reg <= pass3_reg;
            sx4_reg   <= SW'(tax3_reg) + (SW'(qx3_reg) <<< UNIT_BITS)
                         - (SW'(p0x3_reg) <<< FRAC_BITS);
            sy4_reg   <= SW'(tay3_reg) + (SW'(qy3_reg) <<< UNIT_BITS);
            sz4_reg   <= SW'(taz3_reg) + (SW'(qz3_reg) <<< UNIT_BITS)
                         - (SW'(p0z3_reg) <<< FRAC_BITS);

            pass5_reg <= pass4_reg;
            rx5_reg   <= round_q(sx4_reg);
            ry5_reg   <= round_q(sy4_reg);
            rz5_reg   <= round_q(sz4_reg);
        end
    end

    assign satx = sat_q(rx5_reg);
    assign saty = sat_q(ry5_reg);
    assign satz = sat_q(rz5_reg);

    always_comb
    begin
        if (pass5_reg.bump)
        begin
            out_data.x    = $signed(satx[N_W-1:0]);
            out_data.y    = $signed(saty[N_W-1:0]);
            out_data.z    = $signed(satz[N_W-1:0]);
            out_data.clip = satx[N_W] | saty[N_W] | satz[N_W];
        end
        else
        begin
            out_data.x    = pass5_reg.nx;
            out_data.y    = pass5_reg.ny;
            out_data.z    = pass5_reg.nz;
            out_data.clip = 1'b0;
        end
    end

    assign out_valid = valid_reg[4];

endmodule

`default_nettype wire

// ===== design/bump_map_normal_perturb.sv =====
// Tangent-space normal-map perturbation, fully pipelined.
// Input channel: in_valid/in_stall with bump_enable, normal_x/y/z (signed,
// FRAC_BITS fraction bits) and bump_red/green/blue texel channels (low
// TEXEL_BITS bits used). Output channel: out_valid/out_stall with out_x/y/z
// and clipped, which flags a saturated component.
// One transaction enters per cycle while in_stall is low. The result
// passes through the 31-stage restoring divider and the 16-stage
// square-root pipeline that normalize the texel vector and the tangent,
// followed by multiply, sum and rounding stages.
// With bump_enable low the normal passes through unchanged.
// All stages advance together. While out_valid is high and out_stall is
// high, the whole pipeline holds and in_stall is raised; nothing is lost
// or repeated. Reset clears every valid bit, so no stale result appears.
`default_nettype none

module bump_map_normal_perturb #(
    parameter int FRAC_BITS  = 14,
    parameter int TEXEL_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              bump_enable,
    input  logic signed [bmnp_pkg::N_W-1:0]   normal_x,
    input  logic signed [bmnp_pkg::N_W-1:0]   normal_y,
    input  logic signed [bmnp_pkg::N_W-1:0]   normal_z,
    input  logic        [bmnp_pkg::N_W-1:0]   bump_red,
    input  logic        [bmnp_pkg::N_W-1:0]   bump_green,
    input  logic        [bmnp_pkg::N_W-1:0]   bump_blue,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [bmnp_pkg::N_W-1:0]   out_x,
    output logic signed [bmnp_pkg::N_W-1:0]   out_y,
    output logic signed [bmnp_pkg::N_W-1:0]   out_z,
    output logic                              clipped
);
    import bmnp_pkg::*;

    localparam logic [N_W-1:0] TEX_MASK = N_W'((32'd1 << TEXEL_BITS) - 32'd1);
    localparam int SIDE_W = $bits(side_t);

    logic en;

    logic                  s1_valid_reg;
    logic                  s1_bump_reg;
    logic signed [N_W-1:0] s1_nx_reg, s1_ny_reg, s1_nz_reg;
    logic [N_W-1:0]        s1_c_reg [3];

    logic                  s2_valid_reg;
    side_t                 s2_side_reg;
    side_t                 s2_side_next;
    logic [DEN_W-1:0]      s2_sq_reg [3];
    logic [DEN_W-1:0]      s2_sq_next [3];
    logic [DEN_W-1:0]      s2_nx2_reg, s2_nz2_reg;
    logic [N_W-1:0]        ax, az;

    logic                  s3_valid_reg;
    side_t                 s3_side_reg;
    logic [DEN_W-1:0]      s3_dd_reg;
    logic [DEN_W-1:0]      s3_num_reg [3];
    logic [DEN_W-1:0]      s3_tnx_reg, s3_tnz_reg, s3_tden_reg;

    logic [QUO_W-1:0]      quo_k [3];
    logic [QUO_W-1:0]      quo_tx, quo_tz;
    logic [ROOT_BITS-1:0]  root_k [3];
    logic [ROOT_BITS-1:0]  root_tx, root_tz;

    logic                  dl_valid;
    logic [SIDE_W-1:0]     dl_data;
    side_t                 dl_side;

    logic                  s4_valid_reg;
    comb_in_t              s4_data_reg;
    comb_in_t              s4_data_next;

    logic                  cb_valid;
    res_t                  cb_data;

    logic                  out_valid_reg;
    res_t                  out_data_reg;

    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= in_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= dl_valid;
            out_valid_reg <= cb_valid;
        end
    end

    // texel to signed odd value, then square
    for (genvar i = 0; i < 3; i++)
    begin : g_tex
        logic signed [D_W-1:0] d;
        logic [K_W-1:0]        ad;
        assign d  = $signed({1'b0, s1_c_reg[i], 1'b0}) - $signed({2'b0, TEX_MASK});
        assign ad = d[D_W-1] ? K_W'(-d) : K_W'(d);
        assign s2_sq_next[i] = DEN_W'(ad) * DEN_W'(ad);
        assign s2_side_next.neg[i] = d[D_W-1];
    end

    assign ax = s1_nx_reg[N_W-1] ? N_W'(-s1_nx_reg) : N_W'(s1_nx_reg);
    assign az = s1_nz_reg[N_W-1] ? N_W'(-s1_nz_reg) : N_W'(s1_nz_reg);

    assign s2_side_next.pass.bump = s1_bump_reg;
    assign s2_side_next.pass.nx   = s1_nx_reg;
    assign s2_side_next.pass.ny   = s1_ny_reg;
    assign s2_side_next.pass.nz   = s1_nz_reg;
    assign s2_side_next.degen     = (s1_nx_reg == '0) && (s1_nz_reg == '0);
    assign s2_side_next.tz_neg    = (s1_nx_reg > 0 && s1_nz_reg > 0)
                                 || (s1_nx_reg < 0 && s1_nz_reg < 0);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_bump_reg <= bump_enable;
            s1_nx_reg   <= normal_x;
            s1_ny_reg   <= normal_y;
            s1_nz_reg   <= normal_z;
            s1_c_reg[0] <= bump_red & TEX_MASK;
            s1_c_reg[1] <= bump_green & TEX_MASK;
            s1_c_reg[2] <= bump_blue & TEX_MASK;

            s2_side_reg <= s2_side_next;
            s2_sq_reg   <= s2_sq_next;
            s2_nx2_reg  <= DEN_W'(ax) * DEN_W'(ax);
            s2_nz2_reg  <= DEN_W'(az) * DEN_W'(az);

            s3_side_reg <= s2_side_reg;
            s3_dd_reg   <= s2_sq_reg[0] + s2_sq_reg[1] + s2_sq_reg[2];
            s3_num_reg  <= s2_sq_reg;
            s3_tnx_reg  <= s2_nz2_reg;
            s3_tnz_reg  <= s2_nx2_reg;
            // keep the divider away from zero on the degenerate tangent
            s3_tden_reg <= s2_side_reg.degen ? DEN_W'(1) : s2_nx2_reg + s2_nz2_reg;

            s4_data_reg <= s4_data_next;

            out_data_reg <= cb_data;
        end
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_klane
        bmnp_div u_div (
            .clk (clk),
            .en  (en),
            .num (s3_num_reg[i]),
            .den (s3_dd_reg),
            .quo (quo_k[i])
        );

        bmnp_sqrt u_sqrt (
            .clk  (clk),
            .en   (en),
            .val  (quo_k[i]),
            .root (root_k[i])
        );
    end

    bmnp_div u_div_tx (
        .clk (clk),
        .en  (en),
        .num (s3_tnx_reg),
        .den (s3_tden_reg),
        .quo (quo_tx)
    );

    bmnp_div u_div_tz (
        .clk (clk),
        .en  (en),
        .num (s3_tnz_reg),
        .den (s3_tden_reg),
        .quo (quo_tz)
    );

    bmnp_sqrt u_sqrt_tx (
        .clk  (clk),
        .en   (en),
        .val  (quo_tx),
        .root (root_tx)
    );

    bmnp_sqrt u_sqrt_tz (
        .clk  (clk),
        .en   (en),
        .val  (quo_tz),
        .root (root_tz)
    );

    bmnp_delay #(
        .W     (SIDE_W),
        .DEPTH (QUO_W + ROOT_BITS)
    ) u_side (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s3_valid_reg),
        .in_data   (s3_side_reg),
        .out_valid (dl_valid),
        .out_data  (dl_data)
    );

    assign dl_side = side_t'(dl_data);

    always_comb
    begin
        s4_data_next.pass = dl_side.pass;
        s4_data_next.k0   = dl_side.neg[0] ? -$signed({1'b0, root_k[0]})
                                           : $signed({1'b0, root_k[0]});
        s4_data_next.k1   = dl_side.neg[1] ? -$signed({1'b0, root_k[1]})
                                           : $signed({1'b0, root_k[1]});
        s4_data_next.k2   = dl_side.neg[2] ? -$signed({1'b0, root_k[2]})
                                           : $signed({1'b0, root_k[2]});
        if (dl_side.degen)
        begin
            s4_data_next.tx = '0;
            s4_data_next.tz = K_ONE;
        end
        else
        begin
            s4_data_next.tx = $signed({1'b0, root_tx});
            s4_data_next.tz = dl_side.tz_neg ? -$signed({1'b0, root_tz})
                                             : $signed({1'b0, root_tz});
        end
    end

    bmnp_combine #(
        .FRAC_BITS (FRAC_BITS)
    ) u_combine (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s4_valid_reg),
        .in_data   (s4_data_reg),
        .out_valid (cb_valid),
        .out_data  (cb_data)
    );

    assign out_valid = out_valid_reg;
    assign out_x     = out_data_reg.x;
    assign out_y     = out_data_reg.y;
    assign out_z     = out_data_reg.z;
    assign clipped   = out_data_reg.clip;

endmodule

`default_nettype wire

// ===== design/bmnp_checker.sv =====
`default_nettype none
`include "bump_map_normal_perturb_assert.svh"

module bmnp_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_stall,
    input logic                            out_valid,
    input logic                            out_stall,
    input logic signed [bmnp_pkg::N_W-1:0] out_x,
    input logic signed [bmnp_pkg::N_W-1:0] out_y,
    input logic signed [bmnp_pkg::N_W-1:0] out_z,
    input logic                            clipped
);

    // hold a stalled output transaction
    `BMNP_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid)
    `BMNP_ASSERT_NXT(a_out_stable, out_valid && out_stall, $stable(out_x) && $stable(out_y) && $stable(out_z) && $stable(clipped))
    // input backs up only behind a held result
    `BMNP_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall)
    // a clipped result has a component at a rail
    `BMNP_ASSERT_NOW(a_clip_rail, out_valid && clipped, out_x == 16'sh7fff || out_x == 16'sh8000 || out_y == 16'sh7fff || out_y == 16'sh8000 || out_z == 16'sh7fff || out_z == 16'sh8000)

endmodule

bind bump_map_normal_perturb bmnp_checker u_checker (.*);

`default_nettype wire
